// ===== rtl/cylinder_mesh_index_generator_assert.svh =====
// Assertion macros used by the checker module of the mesh index generator.
`ifndef CYLINDER_MESH_INDEX_GENERATOR_ASSERT_SVH
`define CYLINDER_MESH_INDEX_GENERATOR_ASSERT_SVH

// Checked at every rising edge outside of reset.
`define CMIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset cycles included.
`define CMIG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cmig_pkg.sv =====
`timescale 1ns / 1ps

package cmig_pkg;

  localparam int unsigned VTX_W = 13;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned MAT_W = 16;

  typedef logic [VTX_W-1:0] vtx_t;
  typedef logic [MAT_W-1:0] mat_t;

  // Corner counts of the two polygon kinds.
  localparam logic [2:0] CORNERS_TRI  = 3'd3;
  localparam logic [2:0] CORNERS_QUAD = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SEGMENTS      = 3'd0;
  localparam logic [2:0] REG_SECTIONS      = 3'd1;
  localparam logic [2:0] REG_CAP_RINGS     = 3'd2;
  localparam logic [2:0] REG_MATERIAL_LOW  = 3'd3;
  localparam logic [2:0] REG_MATERIAL_HIGH = 3'd4;

  typedef enum logic [1:0] {
    PH_TOP    = 2'd0,
    PH_BOTTOM = 2'd1,
    PH_SIDES  = 2'd2
  } phase_t;

  // Mesh dimensions after saturation into their legal ranges.
  typedef struct packed {
    logic [CNT_W-1:0] segs;
    logic [CNT_W-1:0] sects;
    logic [4:0]       rings;
  } dims_t;

  typedef struct packed {
    dims_t dims;
    mat_t  mat_low;
    mat_t  mat_high;
  } mesh_cfg_t;

  // One classified polygon, handed from the walker to the index unit.
  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] ring;
    logic [CNT_W-1:0] seg;
    logic             seg_wrap;
    logic             band_first;
    logic             band_last;
    logic             upper;
    logic             last;
  } poly_rec_t;

endpackage

// ===== rtl/cylinder_mesh_index_generator.sv =====
`timescale 1ns / 1ps
// An accepted request passes through the two-entry queue, the ring offset stage and the output register.
// Throughput: one polygon per cycle while out_ready holds, set by the one-step walk counters in the front end.
// The two-entry queue and the output register let either side stall on its own.
// Reset (synchronous, rst_n low) restarts the walk at polygon 0 and loads register defaults.
// Mesh constants follow a register write via the config register and the back end's constant registers.

module cylinder_mesh_index_generator import cmig_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned MAX_SECTIONS = 64,
  parameter int unsigned MAX_RINGS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  // Polygon channel
  output logic        out_valid,
  input  logic        out_ready,
  output vtx_t        out_vertex_a,
  output vtx_t        out_vertex_b,
  output vtx_t        out_vertex_c,
  output vtx_t        out_vertex_d,
  output logic [2:0]  out_corner_count,
  output mat_t        out_material,
  output logic        out_last_polygon
);

  // Upper saturation limits, sized so that the widest legal parameter fits.
  localparam logic [8:0] SEG_LIM  = 9'(MAX_SEGMENTS);
  localparam logic [8:0] SECT_LIM = 9'(MAX_SECTIONS);
  localparam logic [6:0] RING_LIM = 7'(MAX_RINGS);

  logic [CNT_W-1:0] segments_r, segments_nxt;
  logic [CNT_W-1:0] sections_r, sections_nxt;
  logic [4:0]       cap_rings_r, cap_rings_nxt;
  mat_t             mat_low_r, mat_low_nxt;
  mat_t             mat_high_r, mat_high_nxt;

  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  mesh_cfg_t        mesh_cfg;

  logic             rec_valid;
  poly_rec_t        rec;
  logic             fifo_full;
  logic             head_valid;
  poly_rec_t        head;
  logic             head_pop;

  // A write lands in the access phase. The low address bits are not decoded.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    segments_nxt  = segments_r;
    sections_nxt  = sections_r;
    cap_rings_nxt = cap_rings_r;
    mat_low_nxt   = mat_low_r;
    mat_high_nxt  = mat_high_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SEGMENTS:      segments_nxt  = pwdata[CNT_W-1:0];
        REG_SECTIONS:      sections_nxt  = pwdata[CNT_W-1:0];
        REG_CAP_RINGS:     cap_rings_nxt = pwdata[4:0];
        REG_MATERIAL_LOW:  mat_low_nxt   = pwdata[MAT_W-1:0];
        REG_MATERIAL_HIGH: mat_high_nxt  = pwdata[MAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEGMENTS:      prdata = {25'b0, segments_r};
      REG_SECTIONS:      prdata = {25'b0, sections_r};
      REG_CAP_RINGS:     prdata = {27'b0, cap_rings_r};
      REG_MATERIAL_LOW:  prdata = {16'b0, mat_low_r};
      REG_MATERIAL_HIGH: prdata = {16'b0, mat_high_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segments_r  <= 7'd8;
      sections_r  <= 7'd3;
      cap_rings_r <= 5'd2;
      mat_low_r   <= 16'd0;
      mat_high_r  <= 16'd1;
    end else begin
      segments_r  <= segments_nxt;
      sections_r  <= sections_nxt;
      cap_rings_r <= cap_rings_nxt;
      mat_low_r   <= mat_low_nxt;
      mat_high_r  <= mat_high_nxt;
    end
  end

  // Register values outside the legal ranges are saturated before use, so
  // every downstream counter and index sees a well-formed mesh.
  always_comb begin
    if (segments_r < 7'd3) begin
      mesh_cfg.dims.segs = 7'd3;
    end else if ({2'b00, segments_r} > SEG_LIM) begin
      mesh_cfg.dims.segs = SEG_LIM[CNT_W-1:0];
    end else begin
      mesh_cfg.dims.segs = segments_r;
    end
    if (sections_r < 7'd1) begin
      mesh_cfg.dims.sects = 7'd1;
    end else if ({2'b00, sections_r} > SECT_LIM) begin
      mesh_cfg.dims.sects = SECT_LIM[CNT_W-1:0];
    end else begin
      mesh_cfg.dims.sects = sections_r;
    end
    if (cap_rings_r < 5'd1) begin
      mesh_cfg.dims.rings = 5'd1;
    end else if ({2'b00, cap_rings_r} > RING_LIM) begin
      mesh_cfg.dims.rings = RING_LIM[4:0];
    end else begin
      mesh_cfg.dims.rings = cap_rings_r;
    end
    mesh_cfg.mat_low  = mat_low_r;
    mesh_cfg.mat_high = mat_high_r;
  end

  // The front end walks phase, ring and segment counters by one polygon per
  // accepted item and tags each polygon with the flags the index unit needs.
  cmig_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .dims       (mesh_cfg.dims),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_ready   (in_ready),
    .rec_valid  (rec_valid),
    .rec        (rec),
    .rec_ready  (~fifo_full)
  );

  cmig_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (rec_valid),
    .push_data  (rec),
    .full       (fifo_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end forms the ring offset product in one stage and the vertex
  // sums in the next, which is also the output register.
  cmig_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (mesh_cfg),
    .head_valid       (head_valid),
    .head             (head),
    .head_pop         (head_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_a     (out_vertex_a),
    .out_vertex_b     (out_vertex_b),
    .out_vertex_c     (out_vertex_c),
    .out_vertex_d     (out_vertex_d),
    .out_corner_count (out_corner_count),
    .out_material     (out_material),
    .out_last_polygon (out_last_polygon)
  );

endmodule

// ===== rtl/cmig_front.sv =====
`timescale 1ns / 1ps

module cmig_front import cmig_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dims_t     dims,
  input  logic      in_valid,
  input  logic      in_restart,
  output logic      in_ready,
  output logic      rec_valid,
  output poly_rec_t rec,
  input  logic      rec_ready
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] ring_r, ring_nxt;
  logic [CNT_W-1:0] seg_r, seg_nxt;

  logic             accept;
  logic             bad;
  phase_t           cur_phase;
  logic [CNT_W-1:0] cur_ring;
  logic [CNT_W-1:0] cur_seg;
  logic [CNT_W-1:0] ring_max;
  logic             seg_wrap;
  logic             ring_end;

  assign in_ready  = rec_ready;
  assign rec_valid = in_valid;
  assign accept    = in_valid & rec_ready;

  // A configuration change can leave the counters outside the mesh; the walk
  // then starts over just as on an explicit restart.
  always_comb begin
    bad = (seg_r >= dims.segs);
    case (phase_r)
      PH_TOP, PH_BOTTOM: bad = bad | (ring_r >= {2'b00, dims.rings});
      PH_SIDES:          bad = bad | (ring_r >= dims.sects);
      default:           bad = 1'b1;
    endcase
    if (in_restart || bad) begin
      cur_phase = PH_TOP;
      cur_ring  = '0;
      cur_seg   = '0;
    end else begin
      cur_phase = phase_r;
      cur_ring  = ring_r;
      cur_seg   = seg_r;
    end
    ring_max = (cur_phase == PH_SIDES) ? dims.sects - 7'd1
                                       : {2'b00, dims.rings} - 7'd1;
    seg_wrap = (cur_seg == dims.segs - 7'd1);
    ring_end = (cur_ring == ring_max);
  end

  always_comb begin
    phase_nxt = phase_r;
    ring_nxt  = ring_r;
    seg_nxt   = seg_r;
    if (accept) begin
      phase_nxt = cur_phase;
      ring_nxt  = cur_ring;
      seg_nxt   = cur_seg + 7'd1;
      if (seg_wrap) begin
        seg_nxt  = '0;
        ring_nxt = cur_ring + 7'd1;
        if (ring_end) begin
          ring_nxt = '0;
          case (cur_phase)
            PH_TOP:    phase_nxt = PH_BOTTOM;
            PH_BOTTOM: phase_nxt = PH_SIDES;
            default:   phase_nxt = PH_TOP;
          endcase
        end
      end
    end
  end

  always_comb begin
    rec.phase      = cur_phase;
    rec.ring       = cur_ring;
    rec.seg        = cur_seg;
    rec.seg_wrap   = seg_wrap;
    rec.band_first = (cur_ring == '0);
    rec.band_last  = (cur_ring == dims.sects - 7'd1);
    rec.upper      = (cur_ring >= (dims.sects >> 1));
    rec.last       = (cur_phase == PH_SIDES) & rec.band_last & seg_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOP;
      ring_r  <= '0;
      seg_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      ring_r  <= ring_nxt;
      seg_r   <= seg_nxt;
    end
  end

endmodule

// ===== rtl/cmig_fifo.sv =====
`timescale 1ns / 1ps

module cmig_fifo import cmig_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  poly_rec_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output poly_rec_t head
);

  poly_rec_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/cmig_back.sv =====
`timescale 1ns / 1ps

module cmig_back import cmig_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mesh_cfg_t cfg,
  input  logic      head_valid,
  input  poly_rec_t head,
  output logic      head_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output vtx_t      out_vertex_a,
  output vtx_t      out_vertex_b,
  output vtx_t      out_vertex_c,
  output vtx_t      out_vertex_d,
  output logic [2:0] out_corner_count,
  output mat_t      out_material,
  output logic      out_last_polygon
);

  // Mesh constants, refreshed every cycle from the configuration.
  logic [11:0] sr;
  vtx_t        bot_r, bot_nxt;
  vtx_t        mid_r, mid_nxt;
  vtx_t        top_last_r, top_last_nxt;
  vtx_t        bot_last_r, bot_last_nxt;

  // Stage one: ring offset product.
  logic             b1_valid_r, b1_valid_nxt;
  poly_rec_t        b1_rec_r;
  vtx_t             b1_prod_r;
  logic [13:0]      prod_full;

  // Stage two: output register.
  logic             ov_r, ov_nxt;
  vtx_t             va_r, vb_r, vc_r, vd_r;
  vtx_t             va_nxt, vb_nxt, vc_nxt, vd_nxt;
  logic [2:0]       cc_r, cc_nxt;
  mat_t             mat_r, mat_nxt;
  logic             last_r, last_nxt;

  logic             out_load;
  logic             b1_adv;

  vtx_t             base;
  vtx_t             first;
  vtx_t             second;
  vtx_t             seg_v;
  vtx_t             nxt_v;
  vtx_t             mid_off;
  vtx_t             src;
  vtx_t             dst;

  assign out_load = ~ov_r | out_ready;
  assign b1_adv   = ~b1_valid_r | out_load;
  assign head_pop = head_valid & b1_adv;

  assign sr           = {5'b0, cfg.dims.segs} * {7'b0, cfg.dims.rings};
  assign bot_nxt      = {1'b0, sr} + 13'd1;
  assign mid_nxt      = {bot_nxt[VTX_W-2:0], 1'b0};
  assign top_last_nxt = {1'b0, sr} - {6'b0, cfg.dims.segs} + 13'd1;
  assign bot_last_nxt = bot_nxt + top_last_nxt;

  assign prod_full = head.ring * cfg.dims.segs;

  always_comb begin
    b1_valid_nxt = b1_valid_r;
    ov_nxt       = ov_r;
    if (b1_adv) begin
      b1_valid_nxt = head_valid;
    end
    if (out_load) begin
      ov_nxt = b1_valid_r;
    end
  end

  always_comb begin
    seg_v   = {6'b0, b1_rec_r.seg};
    nxt_v   = b1_rec_r.seg_wrap ? '0 : seg_v + 13'd1;
    base    = b1_prod_r + 13'd1;
    first   = base + seg_v;
    second  = b1_rec_r.seg_wrap ? base : first + 13'd1;
    mid_off = mid_r + b1_prod_r;
    src     = b1_rec_r.band_first ? bot_last_r : mid_off - {6'b0, cfg.dims.segs};
    dst     = b1_rec_r.band_last ? top_last_r : mid_off;

    va_nxt   = '0;
    vb_nxt   = '0;
    vc_nxt   = '0;
    vd_nxt   = '0;
    cc_nxt   = CORNERS_TRI;
    mat_nxt  = cfg.mat_high;
    last_nxt = 1'b0;
    case (b1_rec_r.phase)
      PH_TOP: begin
        // The top cap is seen from outside, so its winding is reversed.
        va_nxt = second;
        vb_nxt = first;
      end
      PH_BOTTOM: begin
        va_nxt  = bot_r + first;
        vb_nxt  = bot_r + second;
        vc_nxt  = bot_r;
        mat_nxt = cfg.mat_low;
      end
      default: begin
        va_nxt   = src + nxt_v;
        vb_nxt   = src + seg_v;
        vc_nxt   = dst + seg_v;
        vd_nxt   = dst + nxt_v;
        cc_nxt   = CORNERS_QUAD;
        mat_nxt  = b1_rec_r.upper ? cfg.mat_high : cfg.mat_low;
        last_nxt = b1_rec_r.last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bot_r      <= bot_nxt;
    mid_r      <= mid_nxt;
    top_last_r <= top_last_nxt;
    bot_last_r <= bot_last_nxt;
    if (head_pop) begin
      b1_rec_r  <= head;
      b1_prod_r <= prod_full[VTX_W-1:0];
    end
    if (out_load && b1_valid_r) begin
      va_r   <= va_nxt;
      vb_r   <= vb_nxt;
      vc_r   <= vc_nxt;
      vd_r   <= vd_nxt;
      cc_r   <= cc_nxt;
      mat_r  <= mat_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      b1_valid_r <= b1_valid_nxt;
      ov_r       <= ov_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_vertex_a     = va_r;
  assign out_vertex_b     = vb_r;
  assign out_vertex_c     = vc_r;
  assign out_vertex_d     = vd_r;
  assign out_corner_count = cc_r;
  assign out_material     = mat_r;
  assign out_last_polygon = last_r;

endmodule

// ===== rtl/cmig_port_chk.sv =====
`timescale 1ns / 1ps
`include "cylinder_mesh_index_generator_assert.svh"

module cmig_port_chk import cmig_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input vtx_t       out_vertex_a,
  input vtx_t       out_vertex_d,
  input logic [2:0] out_corner_count,
  input logic       out_last_polygon
);

  `CMIG_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "output valid after reset")
  `CMIG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_vertex_a), "stalled item changed")
  `CMIG_ASSERT(a_tri_no_d, out_valid && out_corner_count == CORNERS_TRI |-> out_vertex_d == '0, "triangle with fourth vertex")
  `CMIG_ASSERT(a_tri_not_last, out_valid && out_corner_count == CORNERS_TRI |-> !out_last_polygon, "cap triangle flagged last")

endmodule

bind cylinder_mesh_index_generator cmig_port_chk u_port_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_vertex_a     (out_vertex_a),
  .out_vertex_d     (out_vertex_d),
  .out_corner_count (out_corner_count),
  .out_last_polygon (out_last_polygon)
);
